// File: rtl/voxel_slab_face_emitter_defines.svh
// ----------------------------------------------------------------------------
// voxel_slab_face_emitter_defines
// Assertion macros shared by the voxel slab face emitter.
// ----------------------------------------------------------------------------
`ifndef VOXEL_SLAB_FACE_EMITTER_DEFINES_SVH
`define VOXEL_SLAB_FACE_EMITTER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define VSFE_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define VSFE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/vsfe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsfe_pkg
// Shared types and constants of the voxel slab face emitter.
// ----------------------------------------------------------------------------
package vsfe_pkg;

  localparam int COORD_BITS_DEF = 8;
  localparam int COLOR_W        = 8;
  localparam int MASK_W         = 6;
  localparam int DIR_W          = 3;
  localparam int NSIDE          = 4;
  localparam int NFACE          = 10;
  localparam int SLOT_W         = 4;
  localparam int JQ_DEPTH       = 4;
  localparam int OQ_DEPTH       = 4;

  localparam int MASK_TOP_BIT   = 4;
  localparam int MASK_BOT_BIT   = 5;

  // slots of the pending-face vector
  localparam int SLOT_TOP = 0;
  localparam int SLOT_C1  = 1;
  localparam int SLOT_C2  = 5;
  localparam int SLOT_BOT = 9;

  typedef enum logic [DIR_W-1:0] {
    DIR_TOP    = 3'd0,
    DIR_NX     = 3'd1,
    DIR_PX     = 3'd2,
    DIR_NY     = 3'd3,
    DIR_PY     = 3'd4,
    DIR_BOTTOM = 3'd5
  } face_dir_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// File: rtl/vsfe_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsfe_fifo
// Small synchronous queue with full/empty status.
// ----------------------------------------------------------------------------
module vsfe_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [W-1:0]      wdata,
  input  logic              pop,
  output logic [W-1:0]      rdata,
  output vsfe_pkg::q_stat_t stat
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem [DEPTH];
  logic [PW-1:0] wptr_r, wptr_nxt;
  logic [PW-1:0] rptr_r, rptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign stat.full  = (cnt_r == CW'(DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign rdata      = mem[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == PW'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == PW'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr_r] <= wdata;
    end
  end

endmodule

// File: rtl/vsfe_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsfe_front
// Tracks slab and run state per voxel and packs the faces it causes into a job.
// ----------------------------------------------------------------------------
module vsfe_front #(
  parameter int COORD_BITS = vsfe_pkg::COORD_BITS_DEF,
  parameter int JOB_W      = 1
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         accept,
  input  logic [COORD_BITS-1:0]        col_x,
  input  logic [COORD_BITS-1:0]        col_y,
  input  logic [COORD_BITS-1:0]        slab_top,
  input  logic [vsfe_pkg::COLOR_W-1:0] voxel_color,
  input  logic [vsfe_pkg::MASK_W-1:0]  cull_mask,
  input  logic                         first_voxel,
  input  logic                         last_voxel,
  output logic                         job_push,
  output logic [JOB_W-1:0]             job
);

  localparam int ZW = COORD_BITS + 1;
  localparam logic [ZW-1:0] Z_LIMIT = {1'b1, {COORD_BITS{1'b0}}};

  logic [ZW-1:0]                run_start_z_r, run_start_z_nxt;
  logic [vsfe_pkg::COLOR_W-1:0] run_color_r, run_color_nxt;
  logic [ZW-1:0]                next_z_r, next_z_nxt;
  logic                         in_slab_r, in_slab_nxt;

  logic [ZW-1:0]                top_z, nz0;
  logic                         start;
  logic [vsfe_pkg::NFACE-1:0]   pend;
  logic [ZW-1:0]                c1_zf, c1_zt;
  logic [vsfe_pkg::COLOR_W-1:0] c1_col;

  assign top_z = {1'b0, slab_top};
  assign start = first_voxel || !in_slab_r;

  always_comb begin
    pend            = '0;
    c1_zf           = run_start_z_r;
    c1_zt           = next_z_r;
    c1_col          = run_color_r;
    run_start_z_nxt = run_start_z_r;
    run_color_nxt   = run_color_r;
    nz0             = next_z_r;
    in_slab_nxt     = in_slab_r;

    if (start) begin
      in_slab_nxt     = 1'b1;
      run_start_z_nxt = top_z;
      nz0             = top_z;
      run_color_nxt   = voxel_color;
      pend[vsfe_pkg::SLOT_TOP] = first_voxel && cull_mask[vsfe_pkg::MASK_TOP_BIT];
    end else if (voxel_color != run_color_r) begin
      // color change closes the open run
      pend[vsfe_pkg::SLOT_C1 +: vsfe_pkg::NSIDE] = cull_mask[vsfe_pkg::NSIDE-1:0];
      run_start_z_nxt = next_z_r;
      run_color_nxt   = voxel_color;
    end

    next_z_nxt = (nz0 < Z_LIMIT) ? nz0 + 1'b1 : nz0;

    if (last_voxel) begin
      pend[vsfe_pkg::SLOT_C2 +: vsfe_pkg::NSIDE] = cull_mask[vsfe_pkg::NSIDE-1:0];
      pend[vsfe_pkg::SLOT_BOT] = cull_mask[vsfe_pkg::MASK_BOT_BIT];
      in_slab_nxt = 1'b0;
    end
  end

  // second closing run spans run_start_z_nxt..next_z_nxt; bottom plane is next_z_nxt
  assign job = {col_x, col_y, voxel_color, pend, slab_top,
                c1_zf, c1_zt, c1_col,
                run_start_z_nxt, next_z_nxt, run_color_nxt};
  assign job_push = accept && (|pend);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_start_z_r <= '0;
      run_color_r   <= '0;
      next_z_r      <= '0;
      in_slab_r     <= 1'b0;
    end else if (accept) begin
      run_start_z_r <= run_start_z_nxt;
      run_color_r   <= run_color_nxt;
      next_z_r      <= next_z_nxt;
      in_slab_r     <= in_slab_nxt;
    end
  end

endmodule

// File: rtl/vsfe_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsfe_back
// Walks the pending faces of one job, one face per cycle while the output queue has room, lowest slot first.
// ----------------------------------------------------------------------------
module vsfe_back #(
  parameter int COORD_BITS = vsfe_pkg::COORD_BITS_DEF,
  parameter int JOB_W      = 1,
  parameter int FACE_W     = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [JOB_W-1:0]  job,
  input  vsfe_pkg::q_stat_t jq_stat,
  output logic              jq_pop,
  input  vsfe_pkg::q_stat_t oq_stat,
  output logic              oq_push,
  output logic [FACE_W-1:0] face
);

  localparam int ZW = COORD_BITS + 1;
  localparam int CW = vsfe_pkg::COLOR_W;

  logic [vsfe_pkg::NFACE-1:0] pend_r, pend_nxt;
  logic [JOB_W-1:0]           job_r;

  logic [COORD_BITS-1:0]      j_x, j_y, j_top;
  logic [CW-1:0]              j_col, j_c1col, j_c2col;
  logic [vsfe_pkg::NFACE-1:0] j_pend;
  logic [ZW-1:0]              j_c1zf, j_c1zt, j_c2zf, j_c2zt;

  logic [vsfe_pkg::NFACE-1:0] lowbit, rest;
  logic [vsfe_pkg::SLOT_W-1:0] sel;
  logic                       busy, emit, load;
  vsfe_pkg::face_dir_t        dir;
  logic [ZW-1:0]              zf, zt;
  logic [CW-1:0]              fcol;

  // pending slots of the job at the queue head
  function automatic logic [vsfe_pkg::NFACE-1:0] j_pend_in();
    return job[JOB_W-2*COORD_BITS-CW-1 -: vsfe_pkg::NFACE];
  endfunction

  assign {j_x, j_y, j_col, j_pend, j_top, j_c1zf, j_c1zt, j_c1col,
          j_c2zf, j_c2zt, j_c2col} = job_r;

  assign busy   = |pend_r;
  assign lowbit = pend_r & (~pend_r + 1'b1);
  assign rest   = pend_r & ~lowbit;
  assign emit   = busy && !oq_stat.full;
  assign load   = !jq_stat.empty && (!busy || (emit && (rest == '0)));
  assign jq_pop = load;
  assign oq_push = emit;

  always_comb begin
    sel = '0;
    for (int i = vsfe_pkg::NFACE - 1; i >= 0; i--) begin
      if (pend_r[i]) begin
        sel = vsfe_pkg::SLOT_W'(i);
      end
    end
  end

  always_comb begin
    dir  = vsfe_pkg::DIR_TOP;
    zf   = {1'b0, j_top};
    zt   = {1'b0, j_top};
    fcol = j_col;
    if (sel == vsfe_pkg::SLOT_W'(vsfe_pkg::SLOT_BOT)) begin
      dir = vsfe_pkg::DIR_BOTTOM;
      zf  = j_c2zt;
      zt  = j_c2zt;
    end else if (sel >= vsfe_pkg::SLOT_W'(vsfe_pkg::SLOT_C2)) begin
      dir  = vsfe_pkg::face_dir_t'(vsfe_pkg::DIR_W'(sel - vsfe_pkg::SLOT_W'(vsfe_pkg::SLOT_C2))
             + vsfe_pkg::DIR_W'(vsfe_pkg::DIR_NX));
      zf   = j_c2zf;
      zt   = j_c2zt;
      fcol = j_c2col;
    end else if (sel >= vsfe_pkg::SLOT_W'(vsfe_pkg::SLOT_C1)) begin
      dir  = vsfe_pkg::face_dir_t'(vsfe_pkg::DIR_W'(sel - vsfe_pkg::SLOT_W'(vsfe_pkg::SLOT_C1))
             + vsfe_pkg::DIR_W'(vsfe_pkg::DIR_NX));
      zf   = j_c1zf;
      zt   = j_c1zt;
      fcol = j_c1col;
    end
  end

  assign face = {dir, j_x, j_y, zf, zt, fcol, (rest == '0)};

  always_comb begin
    pend_nxt = pend_r;
    if (load) begin
      pend_nxt = j_pend_in();
    end else if (emit) begin
      pend_nxt = rest;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      job_r <= job;
    end
  end

endmodule

// File: rtl/voxel_slab_face_emitter.sv
`timescale 1ns / 1ps
// path: a face passes the job queue, the back end's job register and the output queue before it is readable
// throughput: one voxel per cycle while the job queue has room; the back end
//   drains one face per cycle while the output queue has room
// reset: rst_n synchronous, active low; clears slab state and empties both queues
// ----------------------------------------------------------------------------
// voxel_slab_face_emitter
// Merges equal-color voxel runs of a vertical slab and emits cap and side faces.
// ----------------------------------------------------------------------------
`include "voxel_slab_face_emitter_defines.svh"

module voxel_slab_face_emitter #(
  parameter int COORD_BITS = vsfe_pkg::COORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_push,
  output logic                          in_full,
  input  logic [COORD_BITS-1:0]         in_col_x,
  input  logic [COORD_BITS-1:0]         in_col_y,
  input  logic [COORD_BITS-1:0]         in_slab_top,
  input  logic [vsfe_pkg::COLOR_W-1:0]  in_voxel_color,
  input  logic [vsfe_pkg::MASK_W-1:0]   in_cull_mask,
  input  logic                          in_first_voxel,
  input  logic                          in_last_voxel,
  output logic                          out_empty,
  input  logic                          out_pop,
  output logic [vsfe_pkg::DIR_W-1:0]    out_face_dir,
  output logic [COORD_BITS-1:0]         out_face_x,
  output logic [COORD_BITS-1:0]         out_face_y,
  output logic [COORD_BITS:0]           out_z_from,
  output logic [COORD_BITS:0]           out_z_to,
  output logic [vsfe_pkg::COLOR_W-1:0]  out_face_color,
  output logic                          out_last_face
);

  localparam int ZW     = COORD_BITS + 1;
  localparam int JOB_W  = 3 * COORD_BITS + 2 * vsfe_pkg::COLOR_W + vsfe_pkg::NFACE
                          + 4 * ZW + vsfe_pkg::COLOR_W;
  localparam int FACE_W = vsfe_pkg::DIR_W + 2 * COORD_BITS + 2 * ZW
                          + vsfe_pkg::COLOR_W + 1;

  logic              accept;
  logic              jq_push, jq_pop, oq_push;
  logic [JOB_W-1:0]  job_in, job_out;
  logic [FACE_W-1:0] face_in, face_out;
  vsfe_pkg::q_stat_t jq_stat, oq_stat;

  assign in_full = jq_stat.full;
  assign accept  = in_push && !jq_stat.full;

  vsfe_front #(
    .COORD_BITS (COORD_BITS),
    .JOB_W      (JOB_W)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .col_x       (in_col_x),
    .col_y       (in_col_y),
    .slab_top    (in_slab_top),
    .voxel_color (in_voxel_color),
    .cull_mask   (in_cull_mask),
    .first_voxel (in_first_voxel),
    .last_voxel  (in_last_voxel),
    .job_push    (jq_push),
    .job         (job_in)
  );

  vsfe_fifo #(
    .W     (JOB_W),
    .DEPTH (vsfe_pkg::JQ_DEPTH)
  ) u_job_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (jq_push),
    .wdata (job_in),
    .pop   (jq_pop),
    .rdata (job_out),
    .stat  (jq_stat)
  );

  vsfe_back #(
    .COORD_BITS (COORD_BITS),
    .JOB_W      (JOB_W),
    .FACE_W     (FACE_W)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .job     (job_out),
    .jq_stat (jq_stat),
    .jq_pop  (jq_pop),
    .oq_stat (oq_stat),
    .oq_push (oq_push),
    .face    (face_in)
  );

  vsfe_fifo #(
    .W     (FACE_W),
    .DEPTH (vsfe_pkg::OQ_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (oq_push),
    .wdata (face_in),
    .pop   (out_pop),
    .rdata (face_out),
    .stat  (oq_stat)
  );

  assign out_empty = oq_stat.empty;
  assign {out_face_dir, out_face_x, out_face_y, out_z_from, out_z_to,
          out_face_color, out_last_face} = face_out;

  // caps are planes
  `VSFE_ASSERT_NOW(a_cap_flat, clk, rst_n,
    !out_empty && (out_face_dir == vsfe_pkg::DIR_TOP || out_face_dir == vsfe_pkg::DIR_BOTTOM),
    out_z_from == out_z_to, "cap face with nonzero z span")

  // side spans never run backwards
  `VSFE_ASSERT_NOW(a_side_order, clk, rst_n,
    !out_empty && out_face_dir != vsfe_pkg::DIR_TOP && out_face_dir != vsfe_pkg::DIR_BOTTOM,
    out_z_from <= out_z_to, "side face with z_from above z_to")

  // a top-cap voxel always leaves a job behind
  `VSFE_ASSERT_NEXT(a_top_job, clk, rst_n,
    accept && in_first_voxel && in_cull_mask[vsfe_pkg::MASK_TOP_BIT],
    !jq_stat.empty, "top cap voxel produced no job")

endmodule
